>>> hw/rtl/playfair_six_square_bigram_cipher_core_macros.svh
// assertion macros for the cipher core checker
`ifndef PLAYFAIR_SIX_SQUARE_BIGRAM_CIPHER_CORE_MACROS_SVH
`define PLAYFAIR_SIX_SQUARE_BIGRAM_CIPHER_CORE_MACROS_SVH

// clocked property, off while reset is held
`define PSQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// signal holds its value across a cycle in which cond is seen
`define PSQ_HOLD(label, cond, sig, msg) \
  `PSQ_ASSERT(label, (cond) |=> $stable(sig), msg)

`endif

>>> hw/rtl/psq_pkg.sv
// shared constants, codes and symbol helpers for the six-square cipher core
`timescale 1ns / 1ps

package psq_pkg;

  // square geometry
  localparam int SIDE   = 6;
  localparam int NSYM   = SIDE * SIDE;
  localparam int NLET   = 26;
  localparam int SYM_W  = $clog2(NSYM);
  localparam int ROW_W  = $clog2(SIDE);

  // ascii anchors
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_Z = 8'h5A;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;

  // item actions
  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_KEY    = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;
  localparam logic [1:0] ACT_ENCODE = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR  = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [ROW_W-1:0] rc_t;

  // character belongs to the A-Z 0-9 alphabet
  function automatic logic sym_ok(logic [7:0] c);
    return ((c >= CH_A) && (c <= CH_Z)) || ((c >= CH_0) && (c <= CH_9));
  endfunction

  // symbol index: letters first, then digits
  function automatic sym_t sym_of(logic [7:0] c);
    logic [7:0] d;
    if ((c >= CH_A) && (c <= CH_Z)) begin
      d = c - CH_A;
      return sym_t'(d);
    end
    d = c - CH_0;
    return sym_t'(d) + sym_t'(NLET);
  endfunction

  // ascii character of a symbol index
  function automatic logic [7:0] ascii_of(sym_t s);
    if (s < sym_t'(NLET)) begin
      return CH_A + 8'(s);
    end
    return CH_0 + 8'(s - sym_t'(NLET));
  endfunction

  // row of a cell: 43/256 stands in for 1/6 over all cells of the square
  function automatic rc_t row_of(sym_t p);
    logic [11:0] prod;
    prod = 12'(p) * 12'd43;
    return rc_t'(prod >> 8);
  endfunction

  // column of a cell given its row
  function automatic rc_t col_of(sym_t p, rc_t row);
    sym_t base;
    base = sym_t'(row) * sym_t'(SIDE);
    return rc_t'(p - base);
  endfunction

  // cell index from row and column
  function automatic sym_t cell_at(rc_t row, rc_t col);
    return sym_t'(row) * sym_t'(SIDE) + sym_t'(col);
  endfunction

endpackage

>>> hw/rtl/psq_ram.sv
// one write port, two read port synchronous memory with registered read data
`timescale 1ns / 1ps

module psq_ram
  import psq_pkg::*;
#(
  parameter int DEPTH = NSYM,
  parameter int WIDTH = SYM_W
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports, registered read data
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

>>> hw/rtl/playfair_six_square_bigram_cipher_core.sv
// Start and key go straight to S_RESP; encode passes S_ADDR and S_CONV, finish S_FILL.
// The next item is taken once the previous one is handed to the output register,
// so no pair is taken while one is in flight; an encode runs the position lookup, then
// the square read through the two memories; finish walks all 36 symbols, one a cycle.
// Reset clears the used mask, fill count, ready flag and handshake state; the
// two memories are not cleared and are fully rewritten before any encode reads them.
`timescale 1ns / 1ps

module playfair_six_square_bigram_cipher_core
  import psq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [7:0] in_char_a,
  input  logic [7:0] in_char_b,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_a,
  output logic [7:0] out_b,
  output logic [1:0] out_status
);

  // controller states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADDR = 3'd1;
  localparam logic [2:0] S_CONV = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [NSYM-1:0] used_r, used_nxt;
  sym_t            fill_r, fill_nxt;
  logic            ready_r, ready_nxt;
  sym_t            walk_r, walk_nxt;
  logic [7:0]      res_a_r, res_a_nxt;
  logic [7:0]      res_b_r, res_b_nxt;
  logic [1:0]      res_st_r, res_st_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_a_r, out_b_r;
  logic [1:0]      out_st_r;

  logic in_acc;
  logic ok_a, ok_b;
  sym_t sym_a, sym_b;
  logic wr_en;
  sym_t wr_sym;
  logic has_room;
  logic out_load;

  sym_t pos_a, pos_b;
  sym_t sq_a, sq_b;
  rc_t  row_a, row_b, col_a, col_b;
  sym_t sq_addr_a, sq_addr_b;

  // input decode
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign ok_a     = sym_ok(in_char_a);
  assign ok_b     = sym_ok(in_char_b);
  assign sym_a    = sym_of(in_char_a);
  assign sym_b    = sym_of(in_char_b);
  assign has_room = (fill_r < sym_t'(NSYM));

  // placement of a key symbol or of the next symbol of the finish walk
  always_comb begin
    wr_sym = (state_r == S_FILL) ? walk_r : sym_a;
    wr_en  = 1'b0;
    if (state_r == S_FILL) begin
      wr_en = !used_r[walk_r] && has_room;
    end else if (in_acc && (in_action == ACT_KEY)) begin
      wr_en = ok_a && !used_r[sym_a] && has_room;
    end
  end

  // cell -> symbol store
  psq_ram #(.DEPTH(NSYM), .WIDTH(SYM_W)) u_square (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (fill_r),
    .wr_data   (wr_sym),
    .rd_addr_a (sq_addr_a),
    .rd_addr_b (sq_addr_b),
    .rd_data_a (sq_a),
    .rd_data_b (sq_b)
  );

  // symbol -> cell store, read with the characters of the accepted beat
  psq_ram #(.DEPTH(NSYM), .WIDTH(SYM_W)) u_where (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_sym),
    .wr_data   (fill_r),
    .rd_addr_a (sym_a),
    .rd_addr_b (sym_b),
    .rd_data_a (pos_a),
    .rd_data_b (pos_b)
  );

  // rectangle corners from the two looked-up cells
  assign row_a     = row_of(pos_a);
  assign row_b     = row_of(pos_b);
  assign col_a     = col_of(pos_a, row_a);
  assign col_b     = col_of(pos_b, row_b);
  assign sq_addr_a = cell_at(row_a, col_b);
  assign sq_addr_b = cell_at(row_b, col_a);

  assign out_load = (state_r == S_RESP) && (!out_valid_r || out_ready);

  // controller
  always_comb begin
    state_nxt  = state_r;
    used_nxt   = used_r;
    fill_nxt   = fill_r;
    ready_nxt  = ready_r;
    walk_nxt   = walk_r;
    res_a_nxt  = res_a_r;
    res_b_nxt  = res_b_r;
    res_st_nxt = res_st_r;

    if (wr_en) begin
      used_nxt[wr_sym] = 1'b1;
      fill_nxt         = fill_r + sym_t'(1);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_a_nxt  = '0;
          res_b_nxt  = '0;
          res_st_nxt = ST_OK;
          state_nxt  = S_RESP;
          unique case (in_action)
            ACT_START: begin
              used_nxt  = '0;
              fill_nxt  = '0;
              ready_nxt = 1'b0;
            end
            ACT_KEY: begin
              if (!ok_a) begin
                res_st_nxt = ST_BAD_CHAR;
              end
            end
            ACT_FINISH: begin
              walk_nxt  = '0;
              state_nxt = S_FILL;
            end
            ACT_ENCODE: begin
              if (!ready_r) begin
                res_st_nxt = ST_NOT_READY;
              end else if (!(ok_a && ok_b)) begin
                res_st_nxt = ST_BAD_CHAR;
              end else begin
                state_nxt = S_ADDR;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_ADDR: begin
        state_nxt = S_CONV;
      end
      S_CONV: begin
        res_a_nxt = ascii_of(sq_a);
        res_b_nxt = ascii_of(sq_b);
        state_nxt = S_RESP;
      end
      S_FILL: begin
        walk_nxt = walk_r + sym_t'(1);
        if (walk_r == sym_t'(NSYM - 1)) begin
          ready_nxt = 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output beat register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      fill_r      <= '0;
      ready_r     <= 1'b0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      fill_r      <= fill_nxt;
      ready_r     <= ready_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_a_r  <= res_a_nxt;
    res_b_r  <= res_b_nxt;
    res_st_r <= res_st_nxt;
    if (out_load) begin
      out_a_r  <= res_a_r;
      out_b_r  <= res_b_r;
      out_st_r <= res_st_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_a      = out_a_r;
  assign out_b      = out_b_r;
  assign out_status = out_st_r;

endmodule

>>> hw/rtl/psq_chk.sv
// port-level checker for the cipher core, bound to the top level
`timescale 1ns / 1ps
`include "playfair_six_square_bigram_cipher_core_macros.svh"

module psq_chk
  import psq_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_a,
  input logic [7:0] out_b,
  input logic [1:0] out_status
);

  // a stalled result beat keeps its payload
  `PSQ_HOLD(a_out_hold, out_valid && !out_ready, {out_a, out_b, out_status}, "stalled beat changed")

  // one item at a time: the block is busy right after an accept
  `PSQ_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "accepted twice in a row")

  // only defined status codes leave the block
  `PSQ_ASSERT(a_status_code, out_valid |-> (out_status == ST_OK) || (out_status == ST_BAD_CHAR) || (out_status == ST_NOT_READY), "undefined status")

  // error beats carry no cipher text
  `PSQ_ASSERT(a_err_zero, out_valid && (out_status != ST_OK) |-> (out_a == 8'd0) && (out_b == 8'd0), "error beat with data")

  // the first cipher character, when nonzero, is drawn from the alphabet
  `PSQ_ASSERT(a_alphabet, out_valid && (out_a != 8'd0) |-> ((out_a >= CH_A) && (out_a <= CH_Z)) || ((out_a >= CH_0) && (out_a <= CH_9)), "cipher char outside alphabet")

endmodule

bind playfair_six_square_bigram_cipher_core psq_chk u_psq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_a      (out_a),
  .out_b      (out_b),
  .out_status (out_status)
);
